/* rtl/core/dfdc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfdc_pkg
// Shared types and constants for the depth frame decimate/convert block.
// ----------------------------------------------------------------------------
package dfdc_pkg;

  localparam int PIX_W     = 16;
  localparam int VAL_W     = 32;
  localparam int CFG_W     = 32;
  localparam int IDX_W     = 3;
  localparam int SW_W      = 13;
  localparam int STEPREG_W = 7;
  localparam int CODE_W    = 17;
  localparam int MODE_W    = 2;

  localparam int DEF_MAX_SOURCE_WIDTH = 4096;
  localparam int DEF_MAX_STEP         = 64;

  // quotient bits resolved by the cell chain; top dividend byte seeds remainder
  localparam int DIV_STEPS  = 32;
  localparam int SEED_W     = 8;
  localparam int DEPTH_SHIFT = 10;
  localparam logic [CODE_W-1:0] DEPTH_MULT = 17'd67109;

  localparam logic [SW_W-1:0]      RST_SOURCE_WIDTH = 13'd640;
  localparam logic [STEPREG_W-1:0] RST_STEP         = 7'd1;

  typedef enum logic [MODE_W-1:0] {
    MODE_RAW   = 2'd0,
    MODE_DEPTH = 2'd1,
    MODE_DISP  = 2'd2
  } mode_e;

  typedef enum logic [IDX_W-1:0] {
    REG_SOURCE_WIDTH = 3'd0,
    REG_COLUMN_STEP  = 3'd1,
    REG_ROW_STEP     = 3'd2,
    REG_NO_SAMPLE    = 3'd3,
    REG_SHADOW       = 3'd4,
    REG_OUTPUT_MODE  = 3'd5,
    REG_DISP_CONST   = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [SW_W-1:0]      source_width;
    logic [STEPREG_W-1:0] column_step;
    logic [STEPREG_W-1:0] row_step;
    logic [CODE_W-1:0]    no_sample;
    logic [CODE_W-1:0]    shadow;
    mode_e                mode;
    logic [CFG_W-1:0]     disp_const;
  } cfg_t;

  // one item travelling down the cell chain
  typedef struct packed {
    logic             vld;
    logic             div;
    logic             bad;
    logic [PIX_W-1:0] rem;
    logic [PIX_W-1:0] dvs;
    logic [VAL_W-1:0] quo;
  } stage_t;

endpackage

/* rtl/core/dfdc_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfdc_front
// Raster counters, decimation select, pixel check and mode setup.
// ----------------------------------------------------------------------------
module dfdc_front #(
  parameter int MAX_SOURCE_WIDTH = dfdc_pkg::DEF_MAX_SOURCE_WIDTH,
  parameter int MAX_STEP         = dfdc_pkg::DEF_MAX_STEP
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       adv_i,
  input  logic                       accept_i,
  input  logic [dfdc_pkg::PIX_W-1:0] pixel_i,
  input  logic                       frame_start_i,
  input  dfdc_pkg::cfg_t             cfg_i,
  output dfdc_pkg::stage_t           stage_o
);

  localparam int POS_W = $clog2(MAX_SOURCE_WIDTH);
  localparam int WID_W = $clog2(MAX_SOURCE_WIDTH + 1);
  localparam int PH_W  = $clog2(MAX_STEP);
  localparam int STP_W = $clog2(MAX_STEP + 1);

  logic [POS_W-1:0] pos_q, pos_d, pos_cur;
  logic [PH_W-1:0]  cph_q, cph_d, cph_cur;
  logic [PH_W-1:0]  rph_q, rph_d, rph_cur;
  logic [WID_W-1:0] weff;
  logic [STP_W-1:0] ceff, reff;
  logic [31:0]      sw32, cs32, rs32;
  logic [POS_W:0]   pos_inc;
  logic [PH_W:0]    cph_inc, rph_inc;
  logic             emit, bad, sat;
  logic [dfdc_pkg::PIX_W+dfdc_pkg::CODE_W-1:0] prod;
  dfdc_pkg::stage_t stage_q, stage_d;

  always_comb begin
    sw32 = 32'(cfg_i.source_width);
    cs32 = 32'(cfg_i.column_step);
    rs32 = 32'(cfg_i.row_step);
    if (sw32 == 32'd0) begin
      weff = WID_W'(1);
    end else if (sw32 > 32'(MAX_SOURCE_WIDTH)) begin
      weff = WID_W'(MAX_SOURCE_WIDTH);
    end else begin
      weff = WID_W'(sw32);
    end
    if (cs32 == 32'd0) begin
      ceff = STP_W'(1);
    end else if (cs32 > 32'(MAX_STEP)) begin
      ceff = STP_W'(MAX_STEP);
    end else begin
      ceff = STP_W'(cs32);
    end
    if (rs32 == 32'd0) begin
      reff = STP_W'(1);
    end else if (rs32 > 32'(MAX_STEP)) begin
      reff = STP_W'(MAX_STEP);
    end else begin
      reff = STP_W'(rs32);
    end
  end

  always_comb begin
    pos_cur = frame_start_i ? '0 : pos_q;
    cph_cur = frame_start_i ? '0 : cph_q;
    rph_cur = frame_start_i ? '0 : rph_q;
    emit    = (cph_cur == '0) && (rph_cur == '0);
    pos_inc = {1'b0, pos_cur} + (POS_W+1)'(1);
    cph_inc = {1'b0, cph_cur} + (PH_W+1)'(1);
    rph_inc = {1'b0, rph_cur} + (PH_W+1)'(1);
    cph_d   = (32'(cph_inc) >= 32'(ceff)) ? '0 : cph_inc[PH_W-1:0];
    pos_d   = pos_inc[POS_W-1:0];
    rph_d   = rph_cur;
    if (32'(pos_inc) >= 32'(weff)) begin
      pos_d = '0;
      cph_d = '0;
      rph_d = (32'(rph_inc) >= 32'(reff)) ? '0 : rph_inc[PH_W-1:0];
    end
  end

  always_comb begin
    bad  = (pixel_i == '0) ||
           ({1'b0, pixel_i} == cfg_i.no_sample) ||
           ({1'b0, pixel_i} == cfg_i.shadow);
    prod = {{dfdc_pkg::CODE_W{1'b0}}, pixel_i} *
           {{dfdc_pkg::PIX_W{1'b0}}, dfdc_pkg::DEPTH_MULT};
    sat  = {{(dfdc_pkg::PIX_W-dfdc_pkg::SEED_W){1'b0}},
            cfg_i.disp_const[dfdc_pkg::CFG_W-1 -: dfdc_pkg::SEED_W]} >= pixel_i;
    stage_d     = '0;
    stage_d.vld = accept_i && emit;
    stage_d.bad = bad;
    stage_d.dvs = pixel_i;
    stage_d.rem = dfdc_pkg::PIX_W'(cfg_i.disp_const[dfdc_pkg::CFG_W-1 -: dfdc_pkg::SEED_W]);
    if (!bad) begin
      unique case (cfg_i.mode)
        dfdc_pkg::MODE_DEPTH: begin
          stage_d.quo = dfdc_pkg::VAL_W'(prod >> dfdc_pkg::DEPTH_SHIFT);
        end
        dfdc_pkg::MODE_DISP: begin
          stage_d.div = !sat;
          stage_d.quo = sat ? '1 : '0;
        end
        default: begin
          stage_d.quo = dfdc_pkg::VAL_W'(pixel_i);
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      cph_q <= '0;
      rph_q <= '0;
    end else if (accept_i) begin
      pos_q <= pos_d;
      cph_q <= cph_d;
      rph_q <= rph_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
    end else if (adv_i) begin
      stage_q <= stage_d;
    end
  end

  assign stage_o = stage_q;

endmodule

/* rtl/core/dfdc_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfdc_cell
// One restoring division step; other items pass through unchanged.
// ----------------------------------------------------------------------------
module dfdc_cell (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  logic             dbit_i,
  input  dfdc_pkg::stage_t stage_i,
  output dfdc_pkg::stage_t stage_o
);

  logic [dfdc_pkg::PIX_W:0] r2, diff;
  logic                     ge;
  dfdc_pkg::stage_t         stage_q, stage_d;

  always_comb begin
    r2      = {stage_i.rem, dbit_i};
    diff    = r2 - {1'b0, stage_i.dvs};
    ge      = r2 >= {1'b0, stage_i.dvs};
    stage_d = stage_i;
    if (stage_i.div) begin
      stage_d.rem = ge ? diff[dfdc_pkg::PIX_W-1:0] : r2[dfdc_pkg::PIX_W-1:0];
      stage_d.quo = {stage_i.quo[dfdc_pkg::VAL_W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
    end else if (adv_i) begin
      stage_q <= stage_d;
    end
  end

  assign stage_o = stage_q;

endmodule

/* rtl/core/depth_frame_decimate_convert_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depth_frame_decimate_convert_top
// Decimates a depth pixel stream and converts kept pixels to mm, m or disparity.
// ----------------------------------------------------------------------------
// One pixel item is accepted per clock while the output is not stalled. Every
// kept pixel passes through one setup register (counters, pixel check, depth
// multiply) and a chain of 32 division cells, one quotient bit each, whose
// last register is the output register. Dropped pixels only advance the
// counters. A stalled output result holds the whole chain and stalls the input.
// ----------------------------------------------------------------------------
module depth_frame_decimate_convert_top #(
  parameter int MAX_SOURCE_WIDTH = dfdc_pkg::DEF_MAX_SOURCE_WIDTH,
  parameter int MAX_STEP         = dfdc_pkg::DEF_MAX_STEP
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [dfdc_pkg::IDX_W-1:0] cfg_idx_i,
  input  logic [dfdc_pkg::CFG_W-1:0] cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [dfdc_pkg::PIX_W-1:0] pixel_i,
  input  logic                       frame_start_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [dfdc_pkg::VAL_W-1:0] value_o,
  output logic                       valid_res_o
);

  localparam int N = dfdc_pkg::DIV_STEPS;

  dfdc_pkg::cfg_t   cfg_q;
  dfdc_pkg::stage_t chain [N+1];
  logic [N-1:0]     dvd_lo;
  logic             adv, accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.source_width <= dfdc_pkg::RST_SOURCE_WIDTH;
      cfg_q.column_step  <= dfdc_pkg::RST_STEP;
      cfg_q.row_step     <= dfdc_pkg::RST_STEP;
      cfg_q.no_sample    <= '0;
      cfg_q.shadow       <= '0;
      cfg_q.mode         <= dfdc_pkg::MODE_DEPTH;
      cfg_q.disp_const   <= '0;
    end else if (cfg_we_i) begin
      unique case (dfdc_pkg::reg_idx_e'(cfg_idx_i))
        dfdc_pkg::REG_SOURCE_WIDTH: begin
          cfg_q.source_width <= cfg_data_i[dfdc_pkg::SW_W-1:0];
        end
        dfdc_pkg::REG_COLUMN_STEP: begin
          cfg_q.column_step <= cfg_data_i[dfdc_pkg::STEPREG_W-1:0];
        end
        dfdc_pkg::REG_ROW_STEP: begin
          cfg_q.row_step <= cfg_data_i[dfdc_pkg::STEPREG_W-1:0];
        end
        dfdc_pkg::REG_NO_SAMPLE: begin
          cfg_q.no_sample <= cfg_data_i[dfdc_pkg::CODE_W-1:0];
        end
        dfdc_pkg::REG_SHADOW: begin
          cfg_q.shadow <= cfg_data_i[dfdc_pkg::CODE_W-1:0];
        end
        dfdc_pkg::REG_OUTPUT_MODE: begin
          cfg_q.mode <= dfdc_pkg::mode_e'(cfg_data_i[dfdc_pkg::MODE_W-1:0]);
        end
        dfdc_pkg::REG_DISP_CONST: begin
          cfg_q.disp_const <= cfg_data_i;
        end
        default: begin
        end
      endcase
    end
  end

  assign adv        = !(chain[N].vld && out_stall_i);
  assign in_stall_o = !adv;
  assign accept     = in_valid_i && adv;
  assign dvd_lo     = {cfg_q.disp_const[dfdc_pkg::CFG_W-dfdc_pkg::SEED_W-1:0],
                       {dfdc_pkg::SEED_W{1'b0}}};

  dfdc_front #(
    .MAX_SOURCE_WIDTH (MAX_SOURCE_WIDTH),
    .MAX_STEP         (MAX_STEP)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .adv_i         (adv),
    .accept_i      (accept),
    .pixel_i       (pixel_i),
    .frame_start_i (frame_start_i),
    .cfg_i         (cfg_q),
    .stage_o       (chain[0])
  );

  for (genvar k = 0; k < N; k++) begin : g_cell
    dfdc_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .dbit_i  (dvd_lo[N-1-k]),
      .stage_i (chain[k]),
      .stage_o (chain[k+1])
    );
  end

  assign out_valid_o = chain[N].vld;
  assign value_o     = chain[N].quo;
  assign valid_res_o = !chain[N].bad;

endmodule

/* rtl/core/dfdc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfdc_checker
// Port-level checks for the depth frame decimate/convert block.
// ----------------------------------------------------------------------------
module dfdc_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_stall_o,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic [dfdc_pkg::VAL_W-1:0] value_o,
  input logic                       valid_res_o
);

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a held result");

  a_full_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("input taken while output held");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !valid_res_o |-> value_o == '0)
    else $error("invalid pixel with nonzero value");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(value_o) && $stable(valid_res_o))
    else $error("stalled result changed");

endmodule

bind depth_frame_decimate_convert_top dfdc_checker u_dfdc_checker (.*);
